// ===== rtl/ffsa_pkg.sv =====
package ffsa_pkg;

    localparam int unsigned SIZE_W   = 17;
    localparam int unsigned GADDR_W  = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OWNER_W  = 8;
    localparam int unsigned ADDR_BITS = 16;
    localparam int unsigned ID_BITS   = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_TOO_BIG    = 3'd2,
        ST_NO_FIT     = 3'd3,
        ST_NO_OWNER   = 3'd4,
        ST_TABLE_FULL = 3'd5
    } t_status;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    localparam logic REG_TOTAL_SIZE = 1'b0;

    // compare unit request
    typedef struct packed {
        logic                want_free;
        logic [SIZE_W-1:0]   size;
        logic [OWNER_W-1:0]  owner;
    } t_cmp_req;

endpackage

// ===== rtl/first_fit_segment_allocator_top.sv =====
// channel   direction  signals
// config    in/out     psel penable pwrite paddr pwdata prdata pready
// request   in         i_start i_kind i_owner_id i_request_size, o_busy
// result    out        o_valid o_granted_address o_status o_free_space
//
// a request goes from accept to result beat through a scan with one compare per
// scanned segment in the table, a merge walk over the table, and a move of each
// entry shifted by a split or a merge
// reset and a total_size write leave one free segment covering the memory
// the result beat is shown for one cycle and cannot be held off
module first_fit_segment_allocator_top #(
    parameter int unsigned MAX_SEGMENTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_kind,
    input  logic [ffsa_pkg::OWNER_W-1:0]       i_owner_id,
    input  logic [ffsa_pkg::SIZE_W-1:0]        i_request_size,
    output logic                               o_valid,
    output logic [ffsa_pkg::GADDR_W-1:0]       o_granted_address,
    output logic [ffsa_pkg::STATUS_W-1:0]      o_status,
    output logic [ffsa_pkg::SIZE_W-1:0]        o_free_space
);
    import ffsa_pkg::*;

    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned LW = ADDR_BITS + 1;
    localparam logic [LW-1:0] CAP = LW'(1) << ADDR_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DECIDE= 7'b0000100,
        S_OPEN  = 7'b0001000,
        S_MERGE = 7'b0010000,
        S_DROP  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [LW-1:0]      r_base  [MAX_SEGMENTS];
    logic [LW-1:0]      r_len   [MAX_SEGMENTS];
    logic [ID_BITS-1:0] r_own   [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] r_free;
    logic [CW-1:0]      r_count;
    logic [LW-1:0]      r_free_total;
    logic [LW-1:0]      r_total;

    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_hit_idx;
    logic               r_found;
    logic [CW-1:0]      r_mv;
    logic               r_kind;
    logic [ID_BITS-1:0] r_owner;
    logic [LW-1:0]      r_size;
    t_status            r_status;
    logic [LW-1:0]      r_addr;

    logic               wr_cfg;
    logic [LW-1:0]      cfg_size;
    t_cmp_req           cmp_req;
    logic               cmp_hit;
    logic [IW-1:0]      scan_i;
    logic [OWNER_W-1:0] own_ext;
    logic [SIZE_W-1:0]  len_ext;
    logic [IW-1:0]      hit_i;
    t_status            dec_status;
    logic               dec_go;
    logic               dec_split;
    logic               mg_end;
    logic               mg_pair;

    assign pready = 1'b1;
    assign prdata = 32'(r_total);
    assign wr_cfg = psel && penable && pwrite && (paddr == REG_TOTAL_SIZE);

    always_comb begin
        logic [SIZE_W-1:0] v;
        v = pwdata[SIZE_W-1:0];
        if (v == '0) begin
            cfg_size = LW'(1);
        end else if (SIZE_W'(v) > SIZE_W'(CAP)) begin
            cfg_size = CAP;
        end else begin
            cfg_size = LW'(v);
        end
    end

    assign scan_i  = r_idx[IW-1:0];
    assign hit_i   = r_hit_idx[IW-1:0];
    assign own_ext = OWNER_W'(r_own[scan_i]);
    assign len_ext = SIZE_W'(r_len[scan_i]);
    assign cmp_req = '{want_free: r_kind, size: SIZE_W'(r_size),
                       owner: OWNER_W'(r_owner)};

    ffsa_cmp u_cmp (
        .i_req     (cmp_req),
        .i_is_free (r_free[scan_i]),
        .i_length  (len_ext),
        .i_owner   (own_ext),
        .o_hit     (cmp_hit)
    );

    assign o_busy = (r_state != S_IDLE);

    assign mg_end  = (r_idx + CW'(1) >= r_count);
    assign mg_pair = r_free[scan_i] && r_free[IW'(r_idx + CW'(1))];

    always_comb begin
        dec_status = ST_OK;
        dec_go     = 1'b0;
        dec_split  = (r_len[hit_i] > r_size);
        if (r_kind == KIND_FREE) begin
            if (!r_found) begin
                dec_status = ST_NO_OWNER;
            end else begin
                dec_go = 1'b1;
            end
        end else if (r_size == '0) begin
            dec_status = ST_ZERO_SIZE;
        end else if (r_size > r_total) begin
            dec_status = ST_TOO_BIG;
        end else if (!r_found) begin
            dec_status = ST_NO_FIT;
        end else if (dec_split && r_count >= CW'(MAX_SEGMENTS)) begin
            dec_status = ST_TABLE_FULL;
        end else begin
            dec_go = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_SCAN;
            S_SCAN:   if (r_idx >= r_count || cmp_hit) n_state = S_DECIDE;
            S_DECIDE: begin
                if (!dec_go) begin
                    n_state = S_DONE;
                end else if (r_kind == KIND_ALLOC && dec_split) begin
                    n_state = S_OPEN;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_OPEN:   if (r_mv <= r_hit_idx + CW'(1)) n_state = S_MERGE;
            S_MERGE: begin
                if (mg_end) begin
                    n_state = S_DONE;
                end else if (mg_pair) begin
                    n_state = S_DROP;
                end
            end
            S_DROP:   if (r_mv + CW'(1) >= r_count) n_state = S_MERGE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // merge pointer walks r_idx; drop shifts entries above r_mv down one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= CW'(1);
            r_free       <= MAX_SEGMENTS'(1);
            r_base[0]    <= '0;
            r_len[0]     <= CAP;
            r_total      <= CAP;
            r_free_total <= CAP;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= (r_state == S_DONE);
            if (wr_cfg) begin
                r_total      <= cfg_size;
                r_free_total <= cfg_size;
                r_count      <= CW'(1);
                r_free       <= MAX_SEGMENTS'(1);
                r_base[0]    <= '0;
                r_len[0]     <= cfg_size;
            end
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_kind  <= i_kind;
                    r_owner <= i_owner_id[ID_BITS-1:0];
                    r_size  <= LW'(i_request_size);
                    r_addr  <= '0;
                end
                S_SCAN: begin
                    if (r_idx < r_count && cmp_hit) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_idx;
                    end else if (r_idx < r_count) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_DECIDE: begin
                    r_status <= dec_status;
                    if (dec_go) begin
                        r_idx <= '0;
                        if (r_kind == KIND_FREE) begin
                            r_free[hit_i] <= 1'b1;
                            r_free_total  <= r_free_total + r_len[hit_i];
                        end else begin
                            r_addr        <= r_base[hit_i];
                            r_free[hit_i] <= 1'b0;
                            r_own[hit_i]  <= r_owner;
                            r_free_total  <= r_free_total - r_size;
                            if (dec_split) begin
                                r_mv <= r_count;
                            end
                        end
                    end
                end
                S_OPEN: begin
                    if (r_mv > r_hit_idx + CW'(1)) begin
                        r_base[r_mv[IW-1:0]] <= r_base[IW'(r_mv - CW'(1))];
                        r_len[r_mv[IW-1:0]]  <= r_len[IW'(r_mv - CW'(1))];
                        r_own[r_mv[IW-1:0]]  <= r_own[IW'(r_mv - CW'(1))];
                        r_free[r_mv[IW-1:0]] <= r_free[IW'(r_mv - CW'(1))];
                        r_mv <= r_mv - CW'(1);
                    end else begin
                        r_base[IW'(r_hit_idx + CW'(1))] <= r_base[hit_i] + r_size;
                        r_len[IW'(r_hit_idx + CW'(1))]  <= r_len[hit_i] - r_size;
                        r_free[IW'(r_hit_idx + CW'(1))] <= 1'b1;
                        r_len[hit_i] <= r_size;
                        r_count      <= r_count + CW'(1);
                    end
                end
                S_MERGE: begin
                    if (!mg_end) begin
                        if (mg_pair) begin
                            r_len[scan_i] <= r_len[scan_i] + r_len[IW'(r_idx + CW'(1))];
                            r_mv          <= r_idx + CW'(1);
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                S_DROP: begin
                    if (r_mv + CW'(1) < r_count) begin
                        r_base[r_mv[IW-1:0]] <= r_base[IW'(r_mv + CW'(1))];
                        r_len[r_mv[IW-1:0]]  <= r_len[IW'(r_mv + CW'(1))];
                        r_own[r_mv[IW-1:0]]  <= r_own[IW'(r_mv + CW'(1))];
                        r_free[r_mv[IW-1:0]] <= r_free[IW'(r_mv + CW'(1))];
                        r_mv    <= r_mv + CW'(1);
                    end else begin
                        r_count <= r_count - CW'(1);
                    end
                end
                S_DONE: begin
                    o_granted_address <= GADDR_W'(r_addr);
                    o_status          <= r_status;
                    o_free_space      <= SIZE_W'(r_free_total);
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(1) && r_count <= CW'(MAX_SEGMENTS))
        else $error("segment count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_IDLE)
        else $error("result beat outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= r_total)
        else $error("free total above size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_granted_address == '0))
        else $error("address on error");
endmodule

// ===== rtl/ffsa_cmp.sv =====
module ffsa_cmp (
    input  ffsa_pkg::t_cmp_req                 i_req,
    input  logic                               i_is_free,
    input  logic [ffsa_pkg::SIZE_W-1:0]        i_length,
    input  logic [ffsa_pkg::OWNER_W-1:0]       i_owner,
    output logic                               o_hit
);
    import ffsa_pkg::*;

    always_comb begin
        if (i_req.want_free) begin
            o_hit = !i_is_free && (i_owner == i_req.owner);
        end else begin
            o_hit = i_is_free && (i_length >= i_req.size);
        end
    end
endmodule

// ===== verif/ffsa_checker.sv =====
module ffsa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    input  logic                          i_start,
    input  logic                          o_busy,
    input  logic                          i_kind,
    input  logic [ffsa_pkg::OWNER_W-1:0]  i_owner_id,
    input  logic [ffsa_pkg::SIZE_W-1:0]   i_request_size,
    input  logic                          o_valid,
    input  logic [ffsa_pkg::GADDR_W-1:0]  o_granted_address,
    input  logic [ffsa_pkg::STATUS_W-1:0] o_status,
    input  logic [ffsa_pkg::SIZE_W-1:0]   o_free_space,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffsa_pkg::*;

    localparam int SEGS = 16;

    typedef struct {
        logic [GADDR_W-1:0] addr;
        t_status            status;
        logic [SIZE_W-1:0]  free_space;
    } t_grant;

    t_grant grant_q[$];

    logic [SIZE_W-1:0]  mem_size;
    logic [SIZE_W:0]    seg_base [SEGS];
    logic [SIZE_W-1:0]  seg_len  [SEGS];
    logic [OWNER_W-1:0] seg_owner[SEGS];
    logic               seg_free [SEGS];
    int                 seg_cnt;
    logic [SIZE_W-1:0]  free_bytes;

    task automatic init_table(input logic [SIZE_W-1:0] sz);
        for (int k = 0; k < SEGS; k++) begin
            seg_base[k] = 0; seg_len[k] = 0; seg_owner[k] = 0; seg_free[k] = 0;
        end
        mem_size = sz;
        seg_len[0] = sz;
        seg_free[0] = 1;
        seg_cnt = 1;
        free_bytes = sz;
    endtask

    function automatic void merge_free();
        int k;
        k = 0;
        while (k + 1 < seg_cnt) begin
            if (seg_free[k] && seg_free[k+1]) begin
                seg_len[k] += seg_len[k+1];
                for (int m = k + 1; m < seg_cnt - 1; m++) begin
                    seg_base[m] = seg_base[m+1]; seg_len[m] = seg_len[m+1];
                    seg_owner[m] = seg_owner[m+1]; seg_free[m] = seg_free[m+1];
                end
                seg_cnt--;
            end else begin
                k++;
            end
        end
    endfunction

    function automatic t_grant serve(input logic kind, input logic [OWNER_W-1:0] own,
                                     input logic [SIZE_W-1:0] sz);
        t_grant g;
        int k;
        logic [SIZE_W-1:0] rest;
        g.addr = 0;
        g.status = ST_OK;
        if (kind == KIND_ALLOC) begin
            if (sz == 0) begin
                g.status = ST_ZERO_SIZE;
            end else if (sz > mem_size) begin
                g.status = ST_TOO_BIG;
            end else begin
                for (k = 0; k < seg_cnt; k++)
                    if (seg_free[k] && seg_len[k] >= sz) break;
                if (k >= seg_cnt) begin
                    g.status = ST_NO_FIT;
                end else if (seg_len[k] > sz && seg_cnt >= SEGS) begin
                    g.status = ST_TABLE_FULL;
                end else begin
                    rest = seg_len[k] - sz;
                    g.addr = seg_base[k][GADDR_W-1:0];
                    seg_len[k] = sz; seg_owner[k] = own; seg_free[k] = 0;
                    if (rest > 0) begin
                        for (int m = seg_cnt; m > k + 1; m--) begin
                            seg_base[m] = seg_base[m-1]; seg_len[m] = seg_len[m-1];
                            seg_owner[m] = seg_owner[m-1]; seg_free[m] = seg_free[m-1];
                        end
                        seg_cnt++;
                        seg_base[k+1] = seg_base[k] + sz;
                        seg_len[k+1] = rest; seg_owner[k+1] = 0; seg_free[k+1] = 1;
                    end
                    free_bytes -= sz;
                    merge_free();
                end
            end
        end else begin
            for (k = 0; k < seg_cnt; k++)
                if (!seg_free[k] && seg_owner[k] == own) break;
            if (k >= seg_cnt) begin
                g.status = ST_NO_OWNER;
            end else begin
                seg_free[k] = 1; seg_owner[k] = 0;
                free_bytes += seg_len[k];
                merge_free();
            end
        end
        g.free_space = free_bytes;
        return g;
    endfunction

    assign pending = grant_q.size();

    always @(posedge i_clk) begin
        t_grant g;
        logic [SIZE_W-1:0] v;
        if (!i_rst_n) begin
            init_table(SIZE_W'(65536));
            grant_q.delete();
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (o_valid) begin
                result_count <= result_count + 1;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result beat addr=%0d status=%0d free=%0d",
                             $time, o_granted_address, o_status, o_free_space);
                    fail_count <= fail_count + 1;
                end else begin
                    g = grant_q.pop_front();
                    if (o_granted_address !== g.addr || o_status !== g.status ||
                        o_free_space !== g.free_space) begin
                        $display("%0t: mismatch exp addr=%0d status=%0d free=%0d, got %0d %0d %0d",
                                 $time, g.addr, g.status, g.free_space,
                                 o_granted_address, o_status, o_free_space);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (i_start && !o_busy)
                grant_q.push_back(serve(i_kind, i_owner_id, i_request_size));
            if (psel && penable && pwrite && pready && paddr == REG_TOTAL_SIZE) begin
                v = pwdata[SIZE_W-1:0];
                if (v == 0) v = 1;
                if (v > SIZE_W'(65536)) v = SIZE_W'(65536);
                init_table(v);
            end
        end
    end
endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ffsa_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0, paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    logic i_start = 0;
    logic o_busy;
    logic i_kind = 0;
    logic [OWNER_W-1:0] i_owner_id = 0;
    logic [SIZE_W-1:0] i_request_size = 0;
    logic o_valid;
    logic [GADDR_W-1:0] o_granted_address;
    logic [STATUS_W-1:0] o_status;
    logic [SIZE_W-1:0] o_free_space;
    int fail_count, pending, result_count;
    int beats = 0;
    int cur_size = 65536;

    always #10 i_clk = ~i_clk;

    first_fit_segment_allocator_top dut (.*);
    ffsa_checker chk (.*);

    task automatic send(input logic kind, input logic [OWNER_W-1:0] own,
                        input logic [SIZE_W-1:0] sz);
        i_start <= 1;
        i_kind <= kind;
        i_owner_id <= own;
        i_request_size <= sz;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        beats++;
    endtask

    task automatic pause(input int n);
        i_start <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        i_start <= 0;
        @(negedge i_clk);
        while (pending != 0 || o_busy) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [31:0] v);
        drain();
        psel <= 1; pwrite <= 1; paddr <= REG_TOTAL_SIZE; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge i_clk);
        cur_size = (v[16:0] == 0) ? 1 : (v[16:0] > 65536 ? 65536 : v[16:0]);
    endtask

    task automatic random_burst(input int n, input int owners);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 50)
                send(KIND_ALLOC, OWNER_W'($urandom_range(owners - 1)),
                     SIZE_W'($urandom_range(1, (cur_size / 6) + 1)));
            else if (r < 88)
                send(KIND_FREE, OWNER_W'($urandom_range(owners - 1)), SIZE_W'($urandom));
            else
                send(1'($urandom), OWNER_W'($urandom), SIZE_W'($urandom_range(131071)));
            if ($urandom_range(3) == 0) pause($urandom_range(1, 60));
        end
    endtask

    initial begin
        int sizes[6];
        sizes = '{16, 1, 100, 4096, 65536, 40000};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed
        send(KIND_ALLOC, 0, 0);
        send(KIND_ALLOC, 1, 65537);
        send(KIND_ALLOC, 2, 131071);
        send(KIND_FREE, 9, 0);
        send(KIND_ALLOC, 255, 65536);
        send(KIND_ALLOC, 3, 1);
        send(KIND_FREE, 255, 131071);
        for (int k = 0; k < 16; k++) send(KIND_ALLOC, OWNER_W'(k), 1);
        send(KIND_FREE, 0, 0);
        send(KIND_FREE, 2, 0);
        send(KIND_ALLOC, 7, 1);
        drain();
        write_size(32'h0);
        send(KIND_ALLOC, 1, 1);
        send(KIND_ALLOC, 1, 1);
        write_size(32'hFFFF_FFFF);
        write_size(32'd65536);
        // random
        for (int p = 0; p < 12; p++) begin
            if (p % 2 == 1) write_size(sizes[p / 2]);
            random_burst(140, (p % 3 == 0) ? 256 : 8);
            if (p == 5) drain();
        end
        drain();
        $display("tb_top: %0d request beats sent, %0d result beats checked across sizes",
                 beats, result_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/ffsa_pkg.sv
rtl/ffsa_cmp.sv
rtl/first_fit_segment_allocator_top.sv
verif/ffsa_checker.sv
verif/tb_top.sv
